### rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and helper functions for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Default element format: Q2.14 in 16 bits
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // Magnitudes are brought below 2^MAG_LIMIT_BITS before squaring
  localparam int MAG_LIMIT_BITS = 27;

  // The norm is taken on N * 2^NORM_SHIFT, which gives four extra fraction bits
  localparam int NORM_SHIFT     = 8;
  localparam int ROOT_EXTRA     = NORM_SHIFT / 2;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

endpackage

### rtl/rmq_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module rmq_isqrt #(
  parameter int IN_W   = 48,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RW = IN_W / 2;

  logic              vld  [0:RW];
  logic [IN_W-1:0]   rad  [0:RW];
  logic [RW:0]       rem  [0:RW];
  logic [RW-1:0]     rt   [0:RW];
  logic [SIDE_W-1:0] side [0:RW];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = side_in;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          take;

    // Bring down the next two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[k][RW-1:0], rad[k][IN_W-1 -: 2]};
      trial = {rt[k], 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= rad[k] << 2;
        side[k+1] <= side[k];
        if (take) begin
          rem[k+1] <= (RW+1)'(cur - trial);
          rt[k+1]  <= {rt[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1] <= (RW+1)'(cur);
          rt[k+1]  <= {rt[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign side_out  = side[RW];

endmodule

### rtl/rmq_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_divider
// Four-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module rmq_divider #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 24,
  parameter int QB     = 16,
  parameter int SIDE_W = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [3:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic [3:0][QB-1:0]     quot,
  output logic [SIDE_W-1:0]      side_out
);

  import rmq_pkg::*;

  localparam int CW = imax(NUM_W, DEN_W + QB);

  logic                vld  [0:QB];
  logic [3:0][CW-1:0]  rem  [0:QB];
  logic [3:0][QB-1:0]  q    [0:QB];
  logic [DEN_W-1:0]    dv   [0:QB];
  logic [SIDE_W-1:0]   side [0:QB];

  assign vld[0]  = in_valid;
  assign dv[0]   = den;
  assign side[0] = side_in;
  assign q[0]    = '0;
  for (genvar j = 0; j < 4; j++) begin : g_init
    assign rem[0][j] = CW'(num[j]);
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [CW-1:0]      dsh;
    logic [3:0]         ge;
    logic [3:0][CW-1:0] rem_next;

    // Compare each lane against the divisor at this bit weight
    always_comb begin
      dsh = CW'(dv[k]) << BIT;
      for (int j = 0; j < 4; j++) begin
        ge[j]       = (rem[k][j] >= dsh);
        rem_next[j] = ge[j] ? (rem[k][j] - dsh) : rem[k][j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
        for (int j = 0; j < 4; j++) begin
          q[k+1][j] <= {q[k][j][QB-2:0], ge[j]};
        end
      end
    end
  end

  assign out_valid = vld[QB];
  assign quot      = q[QB];
  assign side_out  = side[QB];

endmodule

### rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// The square root has RW = MW + 5 root stages and the divider has
//   QB = FRAC_BITS + 2 quotient stages; the square root and divider are fully pipelined.
// Throughput: one matrix per cycle, except while the output buffer is full and blocked.
// A two-entry output buffer lets the pipeline keep taking input while a result waits.
// Reset (synchronous, active high) empties the pipeline and the output buffer.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] m_xx,
  input  logic signed [DATA_WIDTH-1:0] m_xy,
  input  logic signed [DATA_WIDTH-1:0] m_xz,
  input  logic signed [DATA_WIDTH-1:0] m_yx,
  input  logic signed [DATA_WIDTH-1:0] m_yy,
  input  logic signed [DATA_WIDTH-1:0] m_yz,
  input  logic signed [DATA_WIDTH-1:0] m_zx,
  input  logic signed [DATA_WIDTH-1:0] m_zy,
  input  logic signed [DATA_WIDTH-1:0] m_zz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] q_scalar,
  output logic signed [DATA_WIDTH-1:0] q_x,
  output logic signed [DATA_WIDTH-1:0] q_y,
  output logic signed [DATA_WIDTH-1:0] q_z,
  output logic                         degenerate
);

  import rmq_pkg::*;

  localparam int TW    = imax(DATA_WIDTH, FRAC_BITS + 1) + 3;
  localparam int MW    = imin(TW, MAG_LIMIT_BITS);
  localparam int SHN   = TW - MW;
  localparam int SHW   = (SHN > 0) ? $clog2(SHN + 1) : 1;
  localparam int NW    = 2 * MW + 2;
  localparam int SW    = NW + NORM_SHIFT;
  localparam int RW    = SW / 2;
  localparam int NUM_W = imax(MW + FRAC_BITS + ROOT_EXTRA, RW) + 1;
  localparam int QB    = FRAC_BITS + 2;
  localparam int XW    = imax(DATA_WIDTH, QB) + 1;
  localparam int SQ_SIDE = 4 * MW + 5;

  localparam logic [QB-1:0] CAP = (FRAC_BITS < DATA_WIDTH - 1) ?
      (QB'(1) << FRAC_BITS) : QB'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic en;

  // ---------------- stage 1: traces, sums and differences ----------------
  logic                  s1_v;
  logic signed [TW-1:0]  s1_tr [4];
  logic signed [TW-1:0]  s1_d_yz, s1_d_zx, s1_d_xy, s1_s_xy, s1_s_zx, s1_s_yz;
  logic signed [TW-1:0]  xx, xy, xz, yx, yy, yz, zx, zy, zz;

  always_comb begin
    xx = TW'(m_xx); xy = TW'(m_xy); xz = TW'(m_xz);
    yx = TW'(m_yx); yy = TW'(m_yy); yz = TW'(m_yz);
    zx = TW'(m_zx); zy = TW'(m_zy); zz = TW'(m_zz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tr[0] <= ONE + xx + yy + zz;
      s1_tr[1] <= ONE + xx - yy - zz;
      s1_tr[2] <= ONE - xx + yy - zz;
      s1_tr[3] <= ONE - xx - yy + zz;
      s1_d_yz  <= yz - zy;
      s1_d_zx  <= zx - xz;
      s1_d_xy  <= xy - yx;
      s1_s_xy  <= xy + yx;
      s1_s_zx  <= zx + xz;
      s1_s_yz  <= yz + zy;
    end
  end

  // ---------------- stage 2: pick branch, split sign and magnitude -------
  logic                  s2_v;
  logic [3:0][TW-1:0]    s2_mag;
  logic [3:0]            s2_neg;
  logic [1:0]            best;
  logic signed [TW-1:0]  vsel [4];

  always_comb begin
    best = 2'd0;
    if (s1_tr[1] > s1_tr[best]) best = 2'd1;
    if (s1_tr[2] > s1_tr[best]) best = 2'd2;
    if (s1_tr[3] > s1_tr[best]) best = 2'd3;
    unique case (best)
      2'd0: begin
        vsel[0] = s1_tr[0]; vsel[1] = s1_d_yz; vsel[2] = s1_d_zx; vsel[3] = s1_d_xy;
      end
      2'd1: begin
        vsel[0] = s1_d_yz; vsel[1] = s1_tr[1]; vsel[2] = s1_s_xy; vsel[3] = s1_s_zx;
      end
      2'd2: begin
        vsel[0] = s1_d_zx; vsel[1] = s1_s_xy; vsel[2] = s1_tr[2]; vsel[3] = s1_s_yz;
      end
      default: begin
        vsel[0] = s1_d_xy; vsel[1] = s1_s_zx; vsel[2] = s1_s_yz; vsel[3] = s1_tr[3];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s2_neg[i] <= vsel[i][TW-1];
        s2_mag[i] <= vsel[i][TW-1] ? TW'(-vsel[i]) : TW'(vsel[i]);
      end
    end
  end

  // ---------------- stage 3: range reduction -----------------------------
  logic               s3_v;
  logic [3:0][MW-1:0] s3_mag;
  logic [3:0]         s3_neg;
  logic [3:0][MW-1:0] red_mag;

  if (SHN > 0) begin : g_reduce
    logic [TW-1:0]  ormag;
    logic [SHW-1:0] sh;
    always_comb begin
      ormag = s2_mag[0] | s2_mag[1] | s2_mag[2] | s2_mag[3];
      sh    = '0;
      for (int k = 1; k <= SHN; k++) begin
        if (ormag[MW-1+k]) sh = SHW'(k);
      end
      for (int i = 0; i < 4; i++) begin
        red_mag[i] = MW'(s2_mag[i] >> sh);
      end
    end
  end else begin : g_noreduce
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        red_mag[i] = s2_mag[i][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag <= red_mag;
      s3_neg <= s2_neg;
    end
  end

  // ---------------- stage 4: squares --------------------------------------
  logic                 s4_v;
  logic [3:0][2*MW-1:0] s4_sq;
  logic [3:0][MW-1:0]   s4_mag;
  logic [3:0]           s4_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s4_sq[i] <= s3_mag[i] * s3_mag[i];
      end
      s4_mag <= s3_mag;
      s4_neg <= s3_neg;
    end
  end

  // ---------------- stage 5: squared norm --------------------------------
  logic               s5_v;
  logic [NW-1:0]      s5_n;
  logic [3:0][MW-1:0] s5_mag;
  logic [3:0]         s5_neg;
  logic               s5_deg;
  logic [NW-1:0]      nsum;

  assign nsum = NW'(s4_sq[0]) + NW'(s4_sq[1]) + NW'(s4_sq[2]) + NW'(s4_sq[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_n   <= nsum;
      s5_deg <= (nsum == '0);
      s5_mag <= s4_mag;
      s5_neg <= s4_neg;
    end
  end

  // ---------------- square root ------------------------------------------
  logic               sq_v;
  logic [RW-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;
  logic [3:0][MW-1:0] sq_mag;
  logic [3:0]         sq_neg;
  logic               sq_deg;

  rmq_isqrt #(
    .IN_W   (SW),
    .SIDE_W (SQ_SIDE)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_v),
    .radicand  ({s5_n, {NORM_SHIFT{1'b0}}}),
    .side_in   ({s5_mag, s5_neg, s5_deg}),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {sq_mag, sq_neg, sq_deg} = sq_side;

  // ---------------- stage 6: rounded numerators ---------------------------
  logic                  s6_v;
  logic [3:0][NUM_W-1:0] s6_num;
  logic [RW-1:0]         s6_den;
  logic [3:0]            s6_neg;
  logic                  s6_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s6_num[i] <= (NUM_W'(sq_mag[i]) << (FRAC_BITS + ROOT_EXTRA)) +
                     NUM_W'(sq_root >> 1);
      end
      s6_den <= sq_root;
      s6_neg <= sq_neg;
      s6_deg <= sq_deg;
    end
  end

  // ---------------- divide ------------------------------------------------
  logic               dv_v;
  logic [3:0][QB-1:0] dv_q;
  logic [3:0]         dv_neg;
  logic               dv_deg;

  rmq_divider #(
    .NUM_W  (NUM_W),
    .DEN_W  (RW),
    .QB     (QB),
    .SIDE_W (5)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .num       (s6_num),
    .den       (s6_den),
    .side_in   ({s6_neg, s6_deg}),
    .out_valid (dv_v),
    .quot      (dv_q),
    .side_out  ({dv_neg, dv_deg})
  );

  // ---------------- stage 7: clamp, sign, zero-norm ----------------------
  logic                         s7_v;
  logic [3:0][DATA_WIDTH-1:0]   s7_q;
  logic                         s7_deg;
  logic [3:0][DATA_WIDTH-1:0]   fin_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [QB-1:0] qc;
      logic [XW-1:0] ext;
      qc  = (dv_q[i] > CAP) ? CAP : dv_q[i];
      ext = XW'(qc);
      if (dv_neg[i]) ext = XW'(-ext);
      fin_q[i] = dv_deg ? '0 : ext[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_q   <= fin_q;
      s7_deg <= dv_deg;
    end
  end

  // ---------------- output register with skid entry ----------------------
  logic                       sk_v;
  logic [3:0][DATA_WIDTH-1:0] sk_q;
  logic                       sk_deg;
  logic [3:0][DATA_WIDTH-1:0] o_q;
  logic                       push, pop;

  assign pop      = out_valid & out_ready;
  assign en       = ~sk_v | out_ready;
  assign push     = en & s7_v;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (pop) begin
      if (sk_v) begin
        out_valid <= 1'b1;
        sk_v      <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        sk_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sk_v) begin
        o_q        <= sk_q;
        degenerate <= sk_deg;
        sk_q       <= s7_q;
        sk_deg     <= s7_deg;
      end else begin
        o_q        <= s7_q;
        degenerate <= s7_deg;
      end
    end else if (push) begin
      if (out_valid) begin
        sk_q   <= s7_q;
        sk_deg <= s7_deg;
      end else begin
        o_q        <= s7_q;
        degenerate <= s7_deg;
      end
    end
  end

  assign q_scalar = o_q[0];
  assign q_x      = o_q[1];
  assign q_y      = o_q[2];
  assign q_z      = o_q[3];

endmodule

### rtl/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [DATA_WIDTH-1:0] q_scalar,
  input logic signed [DATA_WIDTH-1:0] q_x,
  input logic signed [DATA_WIDTH-1:0] q_y,
  input logic signed [DATA_WIDTH-1:0] q_z,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         degenerate
);

  localparam logic signed [63:0] LIM = 64'sd1 <<< FRAC_BITS;

  // Hold a pending result until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  // Input backpressure only while a result is blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A zero-norm result carries zero components
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> q_scalar == 0 && q_x == 0 && q_y == 0 && q_z == 0)
    else $error("degenerate result with nonzero components");

  // Every component stays within unit magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 64'(q_scalar) <= LIM && 64'(q_scalar) >= -LIM &&
                  64'(q_x) <= LIM && 64'(q_x) >= -LIM &&
                  64'(q_y) <= LIM && 64'(q_y) >= -LIM &&
                  64'(q_z) <= LIM && 64'(q_z) >= -LIM)
    else $error("quaternion component out of range");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_rmq_checker (.*);

### tb/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Sends fixed-point rotation matrices (directed corners, then random
// noisy proper rotations, raw bit patterns and small values) through the converter with
// random gaps on both sides, predicts each quaternion in the testbench and
// compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 60;

  typedef logic signed [DW-1:0] elem_t;

  typedef struct packed {
    elem_t q0, qx, qy, qz;
    logic  degen;
  } quat_t;

  // Predicted quaternions waiting for their transfer, and the checker
  class quat_scoreboard;
    quat_t pending[$];
    int    errors;
    int    matched;
    int    branch_hits[4];

    function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > n) bit_pos >>= 2;
      while (bit_pos != 0) begin
        if (n >= res + bit_pos) begin
          n -= res + bit_pos;
          res = (res >> 1) + bit_pos;
        end else begin
          res >>= 1;
        end
        bit_pos >>= 2;
      end
      return res;
    endfunction

    // Predict the Shepperd result for one matrix
    function automatic void note_matrix(input elem_t m[9]);
      longint xx, xy, xz, yx, yy, yz, zx, zy, zz, one;
      longint tr[4];
      longint vec[4];
      longint unsigned mag[4];
      bit neg[4];
      longint unsigned nsq, root, cap, qv;
      int shamt, best;
      bit big;
      quat_t res;
      xx = m[0]; xy = m[1]; xz = m[2];
      yx = m[3]; yy = m[4]; yz = m[5];
      zx = m[6]; zy = m[7]; zz = m[8];
      one = longint'(1) << FB;
      tr[0] = one + xx + yy + zz;
      tr[1] = one + xx - yy - zz;
      tr[2] = one - xx + yy - zz;
      tr[3] = one - xx - yy + zz;
      best = 0;
      for (int i = 1; i < 4; i++) if (tr[i] > tr[best]) best = i;
      branch_hits[best]++;
      case (best)
        0: begin vec = '{tr[0], yz - zy, zx - xz, xy - yx}; end
        1: begin vec = '{yz - zy, tr[1], xy + yx, zx + xz}; end
        2: begin vec = '{zx - xz, xy + yx, tr[2], yz + zy}; end
        default: begin vec = '{xy - yx, zx + xz, yz + zy, tr[3]}; end
      endcase
      for (int i = 0; i < 4; i++) begin
        neg[i] = vec[i] < 0;
        mag[i] = neg[i] ? -vec[i] : vec[i];
      end
      shamt = 0;
      do begin
        big = 0;
        for (int i = 0; i < 4; i++)
          if ((mag[i] >> shamt) >= (64'd1 << MAG_LIMIT_BITS)) big = 1;
        if (big) shamt++;
      end while (big);
      nsq = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] >>= shamt;
        nsq += mag[i] * mag[i];
      end
      res = '0;
      if (nsq == 0) begin
        res.degen = 1'b1;
      end else begin
        root = root64(nsq << NORM_SHIFT);
        cap = 64'd1 << FB;
        if (cap > (64'd1 << (DW - 1)) - 1) cap = (64'd1 << (DW - 1)) - 1;
        for (int i = 0; i < 4; i++) begin
          qv = ((mag[i] << (FB + ROOT_EXTRA)) + (root >> 1)) / root;
          if (qv > cap) qv = cap;
          if (neg[i]) qv = -qv;
          case (i)
            0: res.q0 = elem_t'(qv);
            1: res.qx = elem_t'(qv);
            2: res.qy = elem_t'(qv);
            default: res.qz = elem_t'(qv);
          endcase
        end
      end
      pending.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction
    function automatic void check_quat(input quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("result with no matrix pending");
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      matched++;
      if (got.q0 !== exp_q.q0) begin
        $error("q_scalar expected %0d actual %0d", exp_q.q0, got.q0); errors++;
      end
      if (got.qx !== exp_q.qx) begin
        $error("q_x expected %0d actual %0d", exp_q.qx, got.qx); errors++;
      end
      if (got.qy !== exp_q.qy) begin
        $error("q_y expected %0d actual %0d", exp_q.qy, got.qy); errors++;
      end
      if (got.qz !== exp_q.qz) begin
        $error("q_z expected %0d actual %0d", exp_q.qz, got.qz); errors++;
      end
      if (got.degen !== exp_q.degen) begin
        $error("degenerate expected %0d actual %0d", exp_q.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic  clk, rst;
  logic  in_valid, in_ready, out_valid, out_ready;
  elem_t m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz;
  elem_t q_scalar, q_x, q_y, q_z;
  logic  degenerate;

  quat_scoreboard quats;
  bit    stim_done;
  bit    hold_off;
  int    sent;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m_xx(m_xx), .m_xy(m_xy), .m_xz(m_xz),
    .m_yx(m_yx), .m_yy(m_yy), .m_yz(m_yz),
    .m_zx(m_zx), .m_zy(m_zy), .m_zz(m_zz),
    .out_valid(out_valid), .out_ready(out_ready),
    .q_scalar(q_scalar), .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one matrix, hold it until the transfer, then predict
  task automatic send_matrix(input elem_t m[9]);
    in_valid <= 1'b1;
    m_xx <= m[0]; m_xy <= m[1]; m_xz <= m[2];
    m_yx <= m[3]; m_yy <= m[4]; m_yz <= m[5];
    m_zx <= m[6]; m_zy <= m[7]; m_zz <= m[8];
    do @(posedge clk); while (!in_ready);
    quats.note_matrix(m);
    sent++;
  endtask

  task automatic send_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Elements of a proper rotation from a random unit quaternion, plus small noise
  function automatic void random_rotation(output elem_t m[9]);
    real a, b, c, d, s;
    real r[9];
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    s = $sqrt(a * a + b * b + c * c + d * d);
    if (s == 0.0) begin a = 1.0; s = 1.0; end
    a /= s; b /= s; c /= s; d /= s;
    r[0] = 1 - 2 * (c * c + d * d); r[1] = 2 * (b * c - a * d); r[2] = 2 * (b * d + a * c);
    r[3] = 2 * (b * c + a * d); r[4] = 1 - 2 * (b * b + d * d); r[5] = 2 * (c * d - a * b);
    r[6] = 2 * (b * d - a * c); r[7] = 2 * (c * d + a * b); r[8] = 1 - 2 * (b * b + c * c);
    for (int i = 0; i < 9; i++)
      m[i] = elem_t'($rtoi(r[i] * 16384.0) + int'($urandom_range(0, 6)) - 3);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        quats.check_quat('{q_scalar, q_x, q_y, q_z, degenerate});
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
    end
  end

  // Long hold-off counted in its own process
  initial begin
    hold_off = 1'b0;
    wait (sent == 300);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // Stimulus
  initial begin
    elem_t m[9];
    elem_t ext[4];
    int mode;
    quats = new();
    stim_done = 1'b0;
    sent = 0;
    in_valid = 1'b0;
    {m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz} = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, half-turns (each branch), ties, extremes
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    ext = '{-32768, 32767, 0, -1};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) m[i] = ext[k];
      send_matrix(m);
    end
    m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(m);
    m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_matrix(m);
    m = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0}; send_matrix(m);
    m = '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768}; send_matrix(m);
    m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767}; send_matrix(m);
    m = '{32767, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(m);

    // Random: mostly rotations, some raw patterns and small values
    for (int n = 0; n < 1550; n++) begin
      send_gap(gap_len());
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        random_rotation(m);
      end else if (mode < 9) begin
        for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom());
      end else begin
        for (int i = 0; i < 9; i++) m[i] = elem_t'(int'($urandom_range(0, 8)) - 4);
      end
      send_matrix(m);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (quats.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    $display("Converted %0d matrices; branches hit: %0d %0d %0d %0d.", quats.matched,
             quats.branch_hits[0], quats.branch_hits[1], quats.branch_hits[2],
             quats.branch_hits[3]);
    if (quats.errors == 0 && quats.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
